// ===== sv/vr2d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vr2d_pkg: shared types and constants for the 2D vector rotator
// Widths, gain and reciprocal constants, arctangent table, cell payload type.
// ----------------------------------------------------------------------------
package vr2d_pkg;

	// port widths
	localparam int IN_W  = 32;
	localparam int ANG_W = 26;

	// internal datapath: Q.24 with headroom for CORDIC growth
	localparam int DATA_W = 42;
	localparam int Z_W    = 34;
	localparam int GUARD  = 8;

	// cell count range and default
	localparam int ROTATION_STAGES_DEF = 16;
	localparam int MAX_STAGES          = 32;

	// gain 0.6072529350 in Q1.30
	localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;
	localparam int GAIN_SHIFT = 30 - GUARD;

	// degrees to binary angle: bam = round(deg * 8192 / 45)
	localparam int DEG_DIV   = 45;
	localparam int DEG_MUL_W = 13;
	localparam int DEG_HALF  = 22;
	// floor(2^32 / 45), quotient estimate is low by at most one
	localparam logic [26:0] RECIP_DIV = 27'd95443717;
	localparam int RECIP_SHIFT = 32;
	// ceil(2^25 / 45), exact quotient for operands below 2^19
	localparam logic [19:0] FRAC_RECIP = 20'd745655;
	localparam int FRAC_SHIFT = 25;

	localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(64'sh4000_0000);
	localparam logic signed [Z_W-1:0] HALF_TURN    = Z_W'(64'sh8000_0000);

	// atan(2^-i) in binary angle units
	localparam logic [31:0] ATAN_BAM [MAX_STAGES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	// payload handed from cell to cell
	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [Z_W-1:0]    z;
	} cell_data_t;

	// fractional part of the angle conversion for a remainder below 45
	// divide by 45 through a reciprocal multiply
	function automatic logic [DEG_MUL_W-1:0] frac_bam(input logic [5:0] rem);
		logic [19:0] num;
		logic [39:0] prod;
		num  = (20'(rem) << DEG_MUL_W) + 20'(DEG_HALF);
		prod = 40'(num) * 40'(FRAC_RECIP);
		return DEG_MUL_W'(prod >> FRAC_SHIFT);
	endfunction

endpackage

// ===== sv/vector_rotate_2d.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_rotate_2d: 2D vector rotation by an angle in degrees
// Q16.16 vector, Q9.16 degrees; CORDIC chain of ROTATION_STAGES cells.
//
//   channel | signals                              | dir | handshake
//   --------+--------------------------------------+-----+-------------------
//   input   | x_in, y_in, angle_degrees            | in  | in_valid/in_ready
//   output  | x_out, y_out                         | out | out_valid/out_ready
//
// one item per cycle while out_ready stays high; registered stages in order:
// 4 preparation stages, one per rotation cell, one output register
// every stage has its own valid bit, so empty slots fill while the output stalls
// in_ready falls only when every stage holds an item and out_ready is low
// asynchronous reset clears all valid bits; no clearing pass
// ----------------------------------------------------------------------------
module vector_rotate_2d #(
	parameter int ROTATION_STAGES = vr2d_pkg::ROTATION_STAGES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [vr2d_pkg::IN_W-1:0]   x_in,
	input  logic signed [vr2d_pkg::IN_W-1:0]   y_in,
	input  logic signed [vr2d_pkg::ANG_W-1:0]  angle_degrees,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [vr2d_pkg::IN_W-1:0]   x_out,
	output logic signed [vr2d_pkg::IN_W-1:0]   y_out
);
	import vr2d_pkg::*;

	logic       ch_valid [ROTATION_STAGES+1];
	logic       ch_ready [ROTATION_STAGES+1];
	cell_data_t ch_data  [ROTATION_STAGES+1];

	// angle conversion, gain removal, fold
	vr2d_prep u_prep (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.x_in          (x_in),
		.y_in          (y_in),
		.angle_degrees (angle_degrees),
		.dn_valid      (ch_valid[0]),
		.dn_ready      (ch_ready[0]),
		.dn_data       (ch_data[0])
	);

	// rotation cells
	for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cell
		vr2d_cell #(
			.STAGE (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (ch_valid[i]),
			.up_ready (ch_ready[i]),
			.up_data  (ch_data[i]),
			.dn_valid (ch_valid[i+1]),
			.dn_ready (ch_ready[i+1]),
			.dn_data  (ch_data[i+1])
		);
	end

	// rounding, saturation, output register
	vr2d_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (ch_valid[ROTATION_STAGES]),
		.up_ready  (ch_ready[ROTATION_STAGES]),
		.up_data   (ch_data[ROTATION_STAGES]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.x_out     (x_out),
		.y_out     (y_out)
	);

endmodule

// ===== sv/vr2d_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vr2d_prep: angle conversion, gain removal and half-turn fold
// Four pipeline stages ahead of the rotation cells.
// ----------------------------------------------------------------------------
module vr2d_prep (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [vr2d_pkg::IN_W-1:0]    x_in,
	input  logic signed [vr2d_pkg::IN_W-1:0]    y_in,
	input  logic signed [vr2d_pkg::ANG_W-1:0]   angle_degrees,
	output logic                                dn_valid,
	input  logic                                dn_ready,
	output vr2d_pkg::cell_data_t                dn_data
);
	import vr2d_pkg::*;

	localparam int PROD_W = 2 * IN_W - 1;
	localparam int DP_W   = ANG_W + 27;
	localparam int AQ_W   = DP_W - RECIP_SHIFT;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	// stage 1 registers
	logic                     neg_s1;
	logic [ANG_W-1:0]         dmag_s1;
	logic [DP_W-1:0]          dprod_s1;
	logic signed [PROD_W-1:0] px_s1, py_s1;
	// stage 2 registers
	logic                     neg_s2;
	logic [AQ_W-1:0]          aq_s2;
	logic [5:0]               rem_s2;
	logic signed [DATA_W-1:0] x_s2, y_s2;
	// stage 3 registers
	logic signed [31:0]       z_s3;
	logic signed [DATA_W-1:0] x_s3, y_s3;
	// stage 4 register
	cell_data_t               d_s4;

	// combinational stage terms
	logic [ANG_W-1:0]         dmag;
	logic [AQ_W-1:0]          aq_est;
	logic [ANG_W:0]           rem_full;
	logic [6:0]               rem_est;
	logic signed [PROD_W-1:0] px_rnd, py_rnd;
	logic [AQ_W+DEG_MUL_W-1:0] mag;
	logic [AQ_W+DEG_MUL_W-1:0] bam;
	logic signed [Z_W-1:0]    z_ext;

	// bubble-collapsing advance chain
	assign en_s4    = !v_s4 || dn_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: angle magnitude times reciprocal of 45, coordinates times gain
	assign dmag = angle_degrees[ANG_W-1] ? (ANG_W'(0) - angle_degrees) : angle_degrees;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			neg_s1   <= angle_degrees[ANG_W-1];
			dmag_s1  <= dmag;
			dprod_s1 <= DP_W'(dmag) * DP_W'(RECIP_DIV);
			px_s1    <= PROD_W'(x_in) * PROD_W'(GAIN_Q30);
			py_s1    <= PROD_W'(y_in) * PROD_W'(GAIN_Q30);
		end
	end

	// stage 2: quotient correction, rounding to Q.24
	assign aq_est   = dprod_s1[DP_W-1:RECIP_SHIFT];
	assign rem_full = {1'b0, dmag_s1} - ((ANG_W+1)'(aq_est) * (ANG_W+1)'(DEG_DIV));
	assign rem_est  = rem_full[6:0];
	assign px_rnd   = px_s1 + (PROD_W'(1) <<< (GAIN_SHIFT - 1));
	assign py_rnd   = py_s1 + (PROD_W'(1) <<< (GAIN_SHIFT - 1));

	always_ff @(posedge clk) begin
		if (en_s2) begin
			neg_s2 <= neg_s1;
			if (rem_est >= 7'(DEG_DIV)) begin
				aq_s2  <= aq_est + AQ_W'(1);
				rem_s2 <= 6'(rem_est - 7'(DEG_DIV));
			end else begin
				aq_s2  <= aq_est;
				rem_s2 <= rem_est[5:0];
			end
			x_s2 <= DATA_W'($signed(px_rnd[PROD_W-1:GAIN_SHIFT]));
			y_s2 <= DATA_W'($signed(py_rnd[PROD_W-1:GAIN_SHIFT]));
		end
	end

	// stage 3: binary angle, wrapped to one turn
	assign mag = {aq_s2, frac_bam(rem_s2)};
	assign bam = neg_s2 ? ((AQ_W+DEG_MUL_W)'(0) - mag) : mag;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			z_s3 <= $signed(bam[31:0]);
			x_s3 <= x_s2;
			y_s3 <= y_s2;
		end
	end

	// stage 4: fold into the right half plane by a half turn
	assign z_ext = Z_W'(z_s3);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			priority if (z_ext > QUARTER_TURN) begin
				d_s4.x <= -x_s3;
				d_s4.y <= -y_s3;
				d_s4.z <= z_ext - HALF_TURN;
			end else if (z_ext < -QUARTER_TURN) begin
				d_s4.x <= -x_s3;
				d_s4.y <= -y_s3;
				d_s4.z <= z_ext + HALF_TURN;
			end else begin
				d_s4.x <= x_s3;
				d_s4.y <= y_s3;
				d_s4.z <= z_ext;
			end
		end
	end

	assign dn_valid = v_s4;
	assign dn_data  = d_s4;

endmodule

// ===== sv/vr2d_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vr2d_cell: one CORDIC micro-rotation
// Turns the vector by atan(2^-STAGE) toward zero residual angle, registered.
// ----------------------------------------------------------------------------
module vr2d_cell #(
	parameter int STAGE = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  vr2d_pkg::cell_data_t up_data,
	output logic                 dn_valid,
	input  logic                 dn_ready,
	output vr2d_pkg::cell_data_t dn_data
);
	import vr2d_pkg::*;

	logic                     valid_q;
	cell_data_t               data_q;
	logic signed [DATA_W-1:0] dx, dy;
	logic signed [Z_W-1:0]    step;

	assign up_ready = !valid_q || dn_ready;

	// floor shifts of the neighbor component
	assign dx   = up_data.y >>> STAGE;
	assign dy   = up_data.x >>> STAGE;
	assign step = Z_W'(ATAN_BAM[STAGE]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	// non-negative residual turns counterclockwise
	always_ff @(posedge clk) begin
		if (up_ready) begin
			if (up_data.z >= 0) begin
				data_q.x <= up_data.x - dx;
				data_q.y <= up_data.y + dy;
				data_q.z <= up_data.z - step;
			end else begin
				data_q.x <= up_data.x + dx;
				data_q.y <= up_data.y - dy;
				data_q.z <= up_data.z + step;
			end
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

// ===== sv/vr2d_post.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vr2d_post: output rounding and saturation
// Rounds Q.24 to Q16.16, clamps to 32 bits and holds the result item.
// ----------------------------------------------------------------------------
module vr2d_post (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             up_valid,
	output logic                             up_ready,
	input  vr2d_pkg::cell_data_t             up_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [vr2d_pkg::IN_W-1:0] x_out,
	output logic signed [vr2d_pkg::IN_W-1:0] y_out
);
	import vr2d_pkg::*;

	logic                     valid_q;
	logic signed [IN_W-1:0]   x_q, y_q;
	logic signed [DATA_W-1:0] xr, yr;
	logic signed [IN_W-1:0]   x_sat, y_sat;

	function automatic logic signed [IN_W-1:0] sat32(input logic signed [DATA_W-1:0] v);
		logic hi_ones, hi_zeros;
		hi_ones  = &v[DATA_W-1:IN_W-1];
		hi_zeros = ~|v[DATA_W-1:IN_W-1];
		if (hi_ones || hi_zeros)
			return v[IN_W-1:0];
		else if (v[DATA_W-1])
			return {1'b1, {(IN_W-1){1'b0}}};
		else
			return {1'b0, {(IN_W-1){1'b1}}};
	endfunction

	// round half up, drop guard bits
	assign xr    = (up_data.x + (DATA_W'(1) <<< (GUARD - 1))) >>> GUARD;
	assign yr    = (up_data.y + (DATA_W'(1) <<< (GUARD - 1))) >>> GUARD;
	assign x_sat = sat32(xr);
	assign y_sat = sat32(yr);

	assign up_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			x_q <= x_sat;
			y_q <= y_sat;
		end
	end

	assign out_valid = valid_q;
	assign x_out     = x_q;
	assign y_out     = y_q;

endmodule

// ===== sv/vr2d_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vr2d_checker: port-level checks for the vector rotator
// Tracks items in flight and checks output hold and readiness.
// ----------------------------------------------------------------------------
module vr2d_checker #(
	parameter int ROTATION_STAGES = vr2d_pkg::ROTATION_STAGES_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [vr2d_pkg::IN_W-1:0] x_out,
	input logic signed [vr2d_pkg::IN_W-1:0] y_out
);
	localparam int MAX_FLIGHT = ROTATION_STAGES + 5;
	localparam int CNT_W      = $clog2(MAX_FLIGHT + 2);

	logic [CNT_W-1:0] flight_q;
	logic             in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flight_q <= '0;
		end else if (in_acc && !out_acc) begin
			flight_q <= flight_q + CNT_W'(1);
		end else if (out_acc && !in_acc) begin
			flight_q <= flight_q - CNT_W'(1);
		end
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(x_out) && $stable(y_out))
		else $error("result item changed while stalled");

	// no result without an item in flight
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> flight_q != '0)
		else $error("result item with nothing in flight");

	// pipeline never holds more than its stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		flight_q <= CNT_W'(MAX_FLIGHT))
		else $error("more items in flight than pipeline stages");

	// an empty output register means the chain can take an item
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output register is empty");

endmodule

bind vector_rotate_2d vr2d_checker #(
	.ROTATION_STAGES (ROTATION_STAGES)
) u_vr2d_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.x_out     (x_out),
	.y_out     (y_out)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for vector_rotate_2d
// Streams Q16.16 vectors with Q9.16 angles through the rotator under random
// gaps and output stalls. Every result is compared, in order, against a
// bit-exact CORDIC predictor. The run covers directed corner items first,
// then about 1450 random items.
// ----------------------------------------------------------------------------
module tb;
	import vr2d_pkg::*;

	localparam int STAGES      = ROTATION_STAGES_DEF;
	localparam int LATENCY     = STAGES + 5;
	localparam int HALF_PERIOD = 6;
	localparam int RST_CYCLES  = 7;
	localparam int N_RANDOM    = 1450;
	localparam int IDLE_LIMIT  = 4000;
	localparam int HOLD_AT     = 150;
	localparam int HOLD_LEN    = 4 * LATENCY + 60;

	localparam longint GAIN_K   = 64'sd652032874;
	localparam longint QUARTER  = 64'sh4000_0000;
	localparam longint HALF     = 64'sh8000_0000;
	localparam longint Q32_MAX  = 64'sd2147483647;
	localparam longint Q32_MIN  = -64'sd2147483648;
	localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] ONE   = 32'sh0001_0000;
	localparam logic signed [25:0] ANG_MAX = 26'sd23592960;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [25:0] ang;
		int                 gap;
		bit                 drain;
	} vec_item_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} rot_vec_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                      in_valid      = 1'b0;
	logic                      in_ready;
	logic signed [IN_W-1:0]    x_in          = '0;
	logic signed [IN_W-1:0]    y_in          = '0;
	logic signed [ANG_W-1:0]   angle_degrees = '0;
	logic                      out_valid;
	logic                      out_ready     = 1'b0;
	logic signed [IN_W-1:0]    x_out;
	logic signed [IN_W-1:0]    y_out;

	vec_item_t pending_vecs[$];
	rot_vec_t  rotated_q[$];

	int n_sent      = 0;
	int n_rotated   = 0;
	int n_saturated = 0;
	int n_errors    = 0;
	int idle_cycles = 0;

	vector_rotate_2d #(
		.ROTATION_STAGES(STAGES)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.x_in         (x_in),
		.y_in         (y_in),
		.angle_degrees(angle_degrees),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.x_out        (x_out),
		.y_out        (y_out)
	);

	// clock
	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	// bit-exact rotation: degrees to binary angle, gain removal, cordic stages
	function automatic rot_vec_t rotate_vector(input logic signed [31:0] xi,
			input logic signed [31:0] yi, input logic signed [25:0] ai);
		longint num, mag, bam, z, x, y, dx, dy;
		logic signed [31:0] bam_lo;
		rot_vec_t res;
		num = longint'(ai) * 64'sd65536;
		mag = (num < 0) ? -num : num;
		mag = (mag + 64'sd180) / 64'sd360;
		bam = (num < 0) ? -mag : mag;
		bam_lo = bam[31:0];
		z = longint'(bam_lo);

		// scale by K into Q.24, round half up
		x = (longint'(xi) * GAIN_K + (64'sd1 <<< 21)) >>> 22;
		y = (longint'(yi) * GAIN_K + (64'sd1 <<< 21)) >>> 22;

		// fold into the right half plane by a half turn
		if (z > QUARTER) begin
			x = -x;
			y = -y;
			z = z - HALF;
		end else if (z < -QUARTER) begin
			x = -x;
			y = -y;
			z = z + HALF;
		end

		for (int i = 0; i < STAGES && i < MAX_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - longint'({32'b0, ATAN_BAM[i]});
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + longint'({32'b0, ATAN_BAM[i]});
			end
		end

		// back to Q16.16 and clamp
		x = (x + 64'sd128) >>> GUARD;
		y = (y + 64'sd128) >>> GUARD;
		if (x > Q32_MAX) x = Q32_MAX;
		if (x < Q32_MIN) x = Q32_MIN;
		if (y > Q32_MAX) y = Q32_MAX;
		if (y < Q32_MIN) y = Q32_MIN;
		res.x = x[31:0];
		res.y = y[31:0];
		return res;
	endfunction

	// idle length: mostly none, sometimes short, rarely long
	function automatic int rand_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [25:0] deg_q(input int d);
		return 26'(d * 65536);
	endfunction

	function automatic logic signed [31:0] rand_coord();
		int k;
		k = $urandom_range(0, 9);
		case (k)
			5, 6: return 32'($urandom_range(0, 2 ** 21)) - 32'sd1048576;
			7: begin
				case ($urandom_range(0, 4))
					0: return C_MAX;
					1: return C_MIN;
					2: return 32'sd0;
					3: return 32'sd1;
					default: return -32'sd1;
				endcase
			end
			8, 9: return 32'($urandom_range(0, 2 ** 25)) - 32'sd16777216;
			default: return 32'($urandom);
		endcase
	endfunction

	function automatic logic signed [25:0] rand_angle();
		int k;
		k = $urandom_range(0, 9);
		case (k)
			7: return deg_q(90 * ($urandom_range(0, 8) - 4)) + 26'($urandom_range(0, 4)) - 26'sd2;
			8: begin
				case ($urandom_range(0, 3))
					0: return ANG_MAX;
					1: return -ANG_MAX;
					2: return 26'sd1;
					default: return -26'sd1;
				endcase
			end
			9: return deg_q(45 * ($urandom_range(0, 16) - 8));
			default: return 26'($urandom_range(0, 2 * 23592960)) - ANG_MAX;
		endcase
	endfunction

	task automatic add_vec(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [25:0] a, input int gap, input bit drain);
		vec_item_t it;
		it.x     = x;
		it.y     = y;
		it.ang   = a;
		it.gap   = gap;
		it.drain = drain;
		pending_vecs.push_back(it);
	endtask

	// reset, stimulus, end of run
	initial begin
		// directed corners: quarter and half turns, full turns, saturation
		add_vec(32'sd0, 32'sd0, 26'sd0, rand_idle(), 1'b0);
		add_vec(ONE, 32'sd0, deg_q(90), rand_idle(), 1'b0);
		add_vec(ONE, 32'sd0, deg_q(-90), rand_idle(), 1'b0);
		add_vec(ONE, 2 * ONE, deg_q(180), rand_idle(), 1'b0);
		add_vec(ONE, 2 * ONE, deg_q(-180), rand_idle(), 1'b0);
		add_vec(32'sh0003_8000, -32'sh0001_4000, ANG_MAX, rand_idle(), 1'b0);
		add_vec(32'sh0003_8000, -32'sh0001_4000, -ANG_MAX, rand_idle(), 1'b0);
		add_vec(C_MAX, C_MAX, deg_q(45), rand_idle(), 1'b0);
		add_vec(C_MIN, C_MIN, deg_q(45), rand_idle(), 1'b0);
		add_vec(C_MAX, C_MIN, 26'sd0, rand_idle(), 1'b0);
		add_vec(C_MIN, C_MAX, 26'sd0, rand_idle(), 1'b0);
		add_vec(C_MIN, 32'sd0, deg_q(90), rand_idle(), 1'b0);
		add_vec(C_MAX, 32'sd0, deg_q(270), rand_idle(), 1'b0);
		add_vec(-32'sd1, 32'sd1, 26'sd1, rand_idle(), 1'b0);
		add_vec(32'sd1, -32'sd1, -26'sd1, rand_idle(), 1'b0);
		add_vec(32'sh0064_0000, 32'sh0032_0000, deg_q(30), rand_idle(), 1'b0);
		add_vec(C_MAX, 32'sd0, deg_q(180), rand_idle(), 1'b0);
		add_vec(C_MIN, C_MIN, deg_q(225), rand_idle(), 1'b0);
		add_vec(32'sh1234_5678, 32'sh9ABC_DEF0, ANG_MAX - 26'sd1, rand_idle(), 1'b0);
		add_vec(-32'sh0007_0000, 32'sh0003_0000, deg_q(-270), rand_idle(), 1'b0);
		add_vec(ONE, ONE, -ANG_MAX + 26'sd1, rand_idle(), 1'b0);
		add_vec(C_MAX, C_MAX, deg_q(-135), rand_idle(), 1'b0);

		// random items; two bursts with no gaps to back up the pipe, one quiet stretch
		for (int i = 0; i < N_RANDOM; i++) begin
			add_vec(rand_coord(), rand_coord(), rand_angle(),
				((i >= 100 && i < 400) || (i >= 800 && i < 1000)) ? 0 : rand_idle(),
				(i == 0 || i == 700 || i == 1200));
		end

		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_vecs.size() != 0 || in_valid) @(posedge clk);
		while (rotated_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);

		if (rotated_q.size() != 0) begin
			$display("%0t: %0d rotations never came out", $time, rotated_q.size());
			n_errors++;
		end
		$display("run: %0d vectors in, %0d checked through %0d cordic stages",
			n_sent, n_rotated, STAGES);
		$display("run: %0d results clamped at the Q16.16 limits, %0d mismatches",
			n_saturated, n_errors);
		if (n_errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// input driver: holds each item until taken, inserts gaps and drain pauses
	int        gap_left = 0;
	int        cur_gap  = 0;
	vec_item_t next_vec;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid      <= 1'b0;
			x_in          <= '0;
			y_in          <= '0;
			angle_degrees <= '0;
			gap_left = 0;
			cur_gap  = 0;
		end else begin
			if (in_valid && in_ready) begin
				rotated_q.push_back(rotate_vector(x_in, y_in, angle_degrees));
				n_sent++;
				gap_left = cur_gap;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else if (pending_vecs.size() != 0 &&
						(!pending_vecs[0].drain || rotated_q.size() == 0)) begin
					next_vec = pending_vecs.pop_front();
					in_valid      <= 1'b1;
					x_in          <= next_vec.x;
					y_in          <= next_vec.y;
					angle_degrees <= next_vec.ang;
					cur_gap = next_vec.gap;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor: checks each result in order and drives back-pressure
	int       stall_left = 0;
	int       hold_left  = 0;
	bit       hold_done  = 1'b0;
	rot_vec_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (rotated_q.size() == 0) begin
					$display("%0t: unexpected result x=%0d y=%0d", $time, x_out, y_out);
					n_errors++;
				end else begin
					want = rotated_q.pop_front();
					if (x_out !== want.x) begin
						$display("%0t: x_out mismatch, expected %0d got %0d",
							$time, want.x, x_out);
						n_errors++;
					end
					if (y_out !== want.y) begin
						$display("%0t: y_out mismatch, expected %0d got %0d",
							$time, want.y, y_out);
						n_errors++;
					end
					if (want.x == C_MAX || want.x == C_MIN ||
							want.y == C_MAX || want.y == C_MIN)
						n_saturated++;
				end
				n_rotated++;
			end

			// one long hold-off while the sender keeps pushing
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (n_rotated == HOLD_AT && !hold_done) begin
				out_ready <= 1'b0;
				hold_done = 1'b1;
				hold_left = HOLD_LEN - 1;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (!(n_rotated >= 850 && n_rotated < 1050) && $urandom_range(0, 3) == 0)
					stall_left = rand_idle();
			end
		end
	end

	// watchdog: nothing moving on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

endmodule
